// File: sv/tcp_flow_highest_ack_table_unit_defines.svh
// ============================================================================
// tcp_flow_highest_ack_table_unit_defines.svh
// Assertion macros shared by the flow table RTL.
// ============================================================================
`ifndef TCP_FLOW_HIGHEST_ACK_TABLE_UNIT_DEFINES_SVH
`define TCP_FLOW_HIGHEST_ACK_TABLE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TFHAT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tfhat: same-cycle check failed");
// next-cycle implication
`define TFHAT_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tfhat: next-cycle check failed");
`else
`define TFHAT_ASSERT_IMP(label, clk, rstn, ante, cons)
`define TFHAT_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: sv/tfhat_pkg.sv
// ============================================================================
// tfhat_pkg
// Types and constants of the TCP flow highest-ack table.
// ============================================================================
package tfhat_pkg;

    // table geometry defaults
    localparam int TFHAT_TABLE_ENTRIES = 8192;
    localparam int TFHAT_BUCKET_WAYS   = 4;

    // protocol and sequence-space limits
    localparam logic [7:0]  TFHAT_PROTO_TCP         = 8'd6;
    localparam logic [31:0] TFHAT_TOP_QUARTER_FLOOR = 32'hC000_0000;
    localparam logic [31:0] TFHAT_LOW_QUARTER_LIMIT = 32'h3FFF_FFFF;

    // bucket hash multipliers
    localparam logic [31:0] TFHAT_HASH_MUL_A = 32'h9E37_79B1;
    localparam logic [31:0] TFHAT_HASH_MUL_B = 32'h85EB_CA6B;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_IGNORED  = 2'd0,
        STATUS_INSERTED = 2'd1,
        STATUS_UPDATED  = 2'd2,
        STATUS_FULL     = 2'd3
    } status_t;

    // one way of a bucket row
    typedef struct packed {
        logic        valid;
        logic [63:0] key_addr;
        logic [31:0] key_ports;
        logic [31:0] highest_ack;
        logic [31:0] expected_ack;
        logic        active;
    } entry_t;

endpackage

// File: sv/tfhat_hash.sv
// ============================================================================
// tfhat_hash
// Five-stage bucket hash: mix of addresses and ports, then modulo bucket
// count by reciprocal multiply with one correction step.
// ============================================================================
module tfhat_hash
    import tfhat_pkg::*;
#(
    parameter int BUCKET_COUNT = TFHAT_TABLE_ENTRIES / TFHAT_BUCKET_WAYS,
    parameter int BUCKET_AW    = 11
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [63:0]          key_addr,
    input  logic [31:0]          key_ports,
    output logic                 done,
    output logic [BUCKET_AW-1:0] bucket
);

    localparam int          STAGES = 5;
    localparam logic [32:0] RECIP  = 33'((64'd1 << 32) / 64'(BUCKET_COUNT));
    localparam logic [31:0] BC32   = 32'(BUCKET_COUNT);

    logic [STAGES-1:0]    vld_reg;
    logic [31:0]          a_reg;
    logic [31:0]          b_reg;
    logic [31:0]          c_reg;
    logic [31:0]          q_reg;
    logic [31:0]          r_reg;
    logic [BUCKET_AW-1:0] bucket_reg;

    logic [31:0] port_mix;
    logic [31:0] a_fold;
    logic [31:0] c_comb;
    logic [64:0] q_prod;

    // stage valid shift line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[STAGES-2:0], start};
        end
    end

    always_comb begin
        port_mix = key_ports * TFHAT_HASH_MUL_A;
        a_fold   = a_reg ^ (a_reg >> 16);
        c_comb   = b_reg ^ (b_reg >> 13);
        q_prod   = 65'(c_comb) * 65'(RECIP);
    end

    // datapath: at most one multiply per stage
    always_ff @(posedge aclk) begin
        a_reg <= key_addr[31:0] ^ key_addr[63:32] ^ port_mix;
        b_reg <= a_fold * TFHAT_HASH_MUL_B;
        c_reg <= c_comb;
        q_reg <= q_prod[63:32];
        r_reg <= c_reg - q_reg * BC32;
        // quotient estimate is at most one low
        bucket_reg <= (r_reg >= BC32) ? BUCKET_AW'(r_reg - BC32) : BUCKET_AW'(r_reg);
    end

    assign done   = vld_reg[STAGES-1];
    assign bucket = bucket_reg;

endmodule

// File: sv/tfhat_bucket_ram.sv
// ============================================================================
// tfhat_bucket_ram
// Simple dual-port bucket memory, one row per bucket, registered read.
// ============================================================================
module tfhat_bucket_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 648
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/tcp_flow_highest_ack_table_unit.sv
// ============================================================================
// tcp_flow_highest_ack_table_unit
// Per-packet TCP flow table keeping the highest ack seen for each flow.
// ============================================================================
// Usage:
//   s_axis carries one parsed packet header per word; m_axis returns exactly
//   one result word per packet, in order.
//   A non-TCP packet goes from acceptance straight to the output register
//   load. A TCP packet passes in order through the bucket hash pipeline,
//   the bucket memory read, the way match, the modify and write back, and
//   the output register load. Packets are handled one at a time;
//   s_axis_tready returns in the cycle after the result is loaded into the
//   output register, so a new packet is taken only after the previous
//   result has been loaded. After reset the block clears all
//   TABLE_ENTRIES / BUCKET_WAYS bucket rows (2048 by default) one row per
//   cycle, with s_axis_tready low.
//   The result sits in an output register: while m_axis_tready is low one
//   further packet is accepted and processed, then the block waits with its
//   result until the output register frees up.
// ============================================================================
`include "tcp_flow_highest_ack_table_unit_defines.svh"

module tcp_flow_highest_ack_table_unit
    import tfhat_pkg::*;
#(
    parameter int TABLE_ENTRIES = TFHAT_TABLE_ENTRIES,
    parameter int BUCKET_WAYS   = TFHAT_BUCKET_WAYS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // protocol[7:0], source_ip[39:8], dest_ip[71:40], source_port[87:72],
    // dest_port[103:88], seq_number[135:104], ack_number[167:136],
    // ip_total_len[183:168], ip_header_words[187:184], tcp_header_words[191:188]
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], highest_ack_out[33:2], expected_ack_out[65:34],
    // ack_advanced[66], flow_active[67], zero[71:68]
    output logic [71:0]  m_axis_tdata
);

    localparam int BUCKET_COUNT = TABLE_ENTRIES / BUCKET_WAYS;
    localparam int BUCKET_AW    = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int WAY_W        = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

    typedef entry_t [BUCKET_WAYS-1:0] row_t;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_HASH   = 6'b000100,
        ST_MATCH  = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_RESP   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [BUCKET_AW-1:0] clr_cnt_reg;
    logic                 hash_start_reg;
    logic                 m_valid_reg;

    // captured packet
    logic [63:0]          addr_reg;
    logic [31:0]          ports_reg;
    logic [31:0]          ack_reg;
    logic [31:0]          seq_reg;
    logic [31:0]          payload_reg;
    logic [31:0]          expected_reg;
    logic [BUCKET_AW-1:0] bucket_reg;

    // match results
    logic                 hit_reg;
    logic                 free_reg;
    logic [WAY_W-1:0]     hit_way_reg;
    logic [WAY_W-1:0]     free_way_reg;
    entry_t               hit_entry_reg;

    // pending result and output word
    status_t     res_status_reg;
    logic [31:0] res_highest_reg;
    logic [31:0] res_expected_reg;
    logic        res_adv_reg;
    logic        res_active_reg;
    status_t     out_status_reg;
    logic [31:0] out_highest_reg;
    logic [31:0] out_expected_reg;
    logic        out_adv_reg;
    logic        out_active_reg;

    logic                 s_accept;
    logic                 is_tcp;
    logic                 out_load;
    logic                 clr_last;
    logic                 hash_done;
    logic [BUCKET_AW-1:0] hash_bucket;
    logic                 mem_wr_en;
    logic [BUCKET_AW-1:0] mem_wr_addr;
    row_t                 mem_wr_row;
    row_t                 mem_rd_row;
    logic [31:0]          payload_next;

    logic                 hit_c;
    logic                 free_c;
    logic [WAY_W-1:0]     hit_way_c;
    logic [WAY_W-1:0]     free_way_c;

    logic                 adv_c;
    entry_t               new_entry;
    logic [WAY_W-1:0]     wr_way;
    row_t                 row_mod;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign is_tcp        = (s_axis_tdata[7:0] == TFHAT_PROTO_TCP);
    assign out_load      = (state_reg == ST_RESP) && (!m_valid_reg || m_axis_tready);
    assign clr_last      = (clr_cnt_reg == BUCKET_AW'(BUCKET_COUNT - 1));

    // payload = ip_total_len - 4*ihl - 4*doff, wrapping
    assign payload_next = 32'(s_axis_tdata[183:168])
                        - {26'd0, s_axis_tdata[187:184], 2'b00}
                        - {26'd0, s_axis_tdata[191:188], 2'b00};

    // bucket hash
    tfhat_hash #(
        .BUCKET_COUNT (BUCKET_COUNT),
        .BUCKET_AW    (BUCKET_AW)
    ) u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (hash_start_reg),
        .key_addr  (addr_reg),
        .key_ports (ports_reg),
        .done      (hash_done),
        .bucket    (hash_bucket)
    );

    // bucket memory
    tfhat_bucket_ram #(
        .DEPTH (BUCKET_COUNT),
        .AW    (BUCKET_AW),
        .DW    ($bits(row_t))
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_row),
        .rd_en   (hash_done),
        .rd_addr (hash_bucket),
        .rd_data (mem_rd_row)
    );

    // state sequencing
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_accept) state_next = is_tcp ? ST_HASH : ST_RESP;
            end
            ST_HASH: begin
                if (hash_done) state_next = ST_MATCH;
            end
            ST_MATCH: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            hash_start_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            hash_start_reg <= s_accept && is_tcp;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + BUCKET_AW'(1);
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // per-way lookup, lowest way wins
    always_comb begin
        hit_c      = 1'b0;
        free_c     = 1'b0;
        hit_way_c  = '0;
        free_way_c = '0;
        for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
            if (mem_rd_row[w].valid) begin
                if (mem_rd_row[w].key_addr == addr_reg &&
                    mem_rd_row[w].key_ports == ports_reg) begin
                    hit_c     = 1'b1;
                    hit_way_c = WAY_W'(w);
                end
            end else begin
                free_c     = 1'b1;
                free_way_c = WAY_W'(w);
            end
        end
    end

    // modify: new contents of the chosen way
    always_comb begin
        adv_c = (ack_reg >= hit_entry_reg.highest_ack) ||
                (hit_entry_reg.highest_ack > TFHAT_TOP_QUARTER_FLOOR &&
                 ack_reg < TFHAT_LOW_QUARTER_LIMIT);
        new_entry.valid     = 1'b1;
        new_entry.key_addr  = addr_reg;
        new_entry.key_ports = ports_reg;
        if (hit_reg) begin
            new_entry.highest_ack  = adv_c ? ack_reg : hit_entry_reg.highest_ack;
            new_entry.expected_ack = hit_entry_reg.active ? hit_entry_reg.expected_ack
                                                          : expected_reg;
            new_entry.active       = 1'b1;
        end else begin
            new_entry.highest_ack  = ack_reg;
            new_entry.expected_ack = expected_reg;
            new_entry.active       = 1'b0;
        end
        wr_way         = hit_reg ? hit_way_reg : free_way_reg;
        row_mod        = mem_rd_row;
        row_mod[wr_way] = new_entry;
    end

    // write back, or zero rows during the clearing sweep
    always_comb begin
        if (state_reg == ST_CLEAR) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_reg;
            mem_wr_row  = '0;
        end else begin
            mem_wr_en   = (state_reg == ST_UPDATE) && (hit_reg || free_reg);
            mem_wr_addr = bucket_reg;
            mem_wr_row  = row_mod;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            addr_reg    <= {s_axis_tdata[71:40], s_axis_tdata[39:8]};
            ports_reg   <= {s_axis_tdata[103:88], s_axis_tdata[87:72]};
            seq_reg     <= s_axis_tdata[135:104];
            ack_reg     <= s_axis_tdata[167:136];
            payload_reg <= payload_next;
        end
        if (state_reg == ST_HASH) begin
            expected_reg <= seq_reg + payload_reg;
        end
        if (hash_done) begin
            bucket_reg <= hash_bucket;
        end
        if (state_reg == ST_MATCH) begin
            hit_reg       <= hit_c;
            free_reg      <= free_c;
            hit_way_reg   <= hit_way_c;
            free_way_reg  <= free_way_c;
            hit_entry_reg <= mem_rd_row[hit_way_c];
        end
        // pending result
        if (s_accept && !is_tcp) begin
            res_status_reg   <= STATUS_IGNORED;
            res_highest_reg  <= '0;
            res_expected_reg <= '0;
            res_adv_reg      <= 1'b0;
            res_active_reg   <= 1'b0;
        end else if (state_reg == ST_UPDATE) begin
            if (hit_reg) begin
                res_status_reg   <= STATUS_UPDATED;
                res_highest_reg  <= new_entry.highest_ack;
                res_expected_reg <= new_entry.expected_ack;
                res_adv_reg      <= adv_c;
                res_active_reg   <= 1'b1;
            end else if (free_reg) begin
                res_status_reg   <= STATUS_INSERTED;
                res_highest_reg  <= ack_reg;
                res_expected_reg <= expected_reg;
                res_adv_reg      <= 1'b1;
                res_active_reg   <= 1'b0;
            end else begin
                res_status_reg   <= STATUS_FULL;
                res_highest_reg  <= '0;
                res_expected_reg <= '0;
                res_adv_reg      <= 1'b0;
                res_active_reg   <= 1'b0;
            end
        end
        // output word
        if (out_load) begin
            out_status_reg   <= res_status_reg;
            out_highest_reg  <= res_highest_reg;
            out_expected_reg <= res_expected_reg;
            out_adv_reg      <= res_adv_reg;
            out_active_reg   <= res_active_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_active_reg, out_adv_reg, out_expected_reg,
                            out_highest_reg, out_status_reg};

    // checks
    `TFHAT_ASSERT_IMP(a_hash_done_in_hash, aclk, aresetn, hash_done, state_reg == ST_HASH)
    `TFHAT_ASSERT_IMP(a_write_states, aclk, aresetn, mem_wr_en, state_reg == ST_CLEAR || state_reg == ST_UPDATE)
    `TFHAT_ASSERT_NXT(a_accept_leaves_idle, aclk, aresetn, s_accept, state_reg == ST_HASH || state_reg == ST_RESP)
    `TFHAT_ASSERT_IMP(a_insert_word, aclk, aresetn, m_valid_reg && out_status_reg == STATUS_INSERTED, out_adv_reg && !out_active_reg)
    `TFHAT_ASSERT_IMP(a_empty_word, aclk, aresetn, m_valid_reg && (out_status_reg == STATUS_IGNORED || out_status_reg == STATUS_FULL), out_highest_reg == 32'd0 && out_expected_reg == 32'd0 && !out_adv_reg && !out_active_reg)

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Stream-level check of the TCP flow highest-ack table.
// ============================================================================
// Packet headers go in on s_axis. A flow-table model inside the scoreboard
// predicts one result word per accepted header, and each m_axis word is
// compared field by field with the oldest prediction. A short directed
// sequence covers the edge cases first. Random traffic follows: mostly
// repeat packets of known flows, plus new flows, groups of flows crowding
// one bucket, and non-TCP noise. The sender idles in bursts. The receiver
// stalls on its own schedule and once holds off for a long stretch.
// ============================================================================
module testbench;
    import tfhat_pkg::*;

    localparam int TABLE_ENTRIES     = TFHAT_TABLE_ENTRIES;
    localparam int BUCKET_WAYS       = TFHAT_BUCKET_WAYS;
    localparam int BUCKETS           = TABLE_ENTRIES / BUCKET_WAYS;
    localparam int RANDOM_TCP_ITEMS  = 1230;
    localparam int POOL_LIMIT        = 256;
    localparam int HOLD_TRIGGER      = 200;
    localparam int LONG_HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES      = 24;
    localparam int REPORT_LIMIT      = 50;
    localparam int TIMEOUT_NS        = 4_000_000;

    // input word, protocol in the low bits
    typedef struct packed {
        logic [3:0]  tcp_header_words;
        logic [3:0]  ip_header_words;
        logic [15:0] ip_total_len;
        logic [31:0] ack_number;
        logic [31:0] seq_number;
        logic [15:0] dest_port;
        logic [15:0] source_port;
        logic [31:0] dest_ip;
        logic [31:0] source_ip;
        logic [7:0]  protocol;
    } packet_t;

    // result word, status in the low bits
    typedef struct packed {
        logic [3:0]  pad;
        logic        flow_active;
        logic        ack_advanced;
        logic [31:0] expected_ack_out;
        logic [31:0] highest_ack_out;
        status_t     status;
    } flow_result_t;

    typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    int unsigned  words_sent;
    int unsigned  burst_left;
    packet_t      flow_pool[$];
    packet_t      crowd_group[$];

    // bucket hash of a stored key
    function automatic int unsigned bucket_index(logic [63:0] addrs, logic [31:0] ports);
        logic [31:0] x;
        x = addrs[31:0] ^ addrs[63:32] ^ (ports * TFHAT_HASH_MUL_A);
        x ^= x >> 16;
        x = x * TFHAT_HASH_MUL_B;
        x ^= x >> 13;
        return x % BUCKETS;
    endfunction

    // flow table model plus the queue of predicted result words
    class ack_table_board;
        bit           entry_valid  [TABLE_ENTRIES];
        logic [63:0]  entry_addrs  [TABLE_ENTRIES];
        logic [31:0]  entry_ports  [TABLE_ENTRIES];
        logic [31:0]  entry_hi_ack [TABLE_ENTRIES];
        logic [31:0]  entry_exp_ack[TABLE_ENTRIES];
        bit           entry_active [TABLE_ENTRIES];
        flow_result_t expected_flow_results[$];
        int           mismatches;

        function flow_result_t predict_flow_result(packet_t p);
            flow_result_t r;
            logic [31:0]  payload;
            logic [31:0]  exp_ack;
            logic [31:0]  hi;
            logic [63:0]  addrs;
            logic [31:0]  ports;
            int unsigned  base;
            int unsigned  idx;
            int unsigned  free_idx;
            bit           have_free;
            r = '0;
            have_free = 1'b0;
            free_idx = 0;
            if (p.protocol != TFHAT_PROTO_TCP) begin
                r.status = STATUS_IGNORED;
                return r;
            end
            // payload wraps when the headers claim more than the packet
            payload = 32'(p.ip_total_len) - 32'(p.ip_header_words) * 32'd4
                      - 32'(p.tcp_header_words) * 32'd4;
            exp_ack = p.seq_number + payload;
            // key is the reverse direction of the packet
            addrs = {p.dest_ip, p.source_ip};
            ports = {p.dest_port, p.source_port};
            base = bucket_index(addrs, ports) * BUCKET_WAYS;
            for (int w = 0; w < BUCKET_WAYS; w++) begin
                idx = base + w;
                if (entry_valid[idx]) begin
                    if (entry_addrs[idx] == addrs && entry_ports[idx] == ports) begin
                        hi = entry_hi_ack[idx];
                        r.status = STATUS_UPDATED;
                        // advance, or wrap from top quarter into bottom quarter
                        if (p.ack_number >= hi || (hi > TFHAT_TOP_QUARTER_FLOOR &&
                                                   p.ack_number < TFHAT_LOW_QUARTER_LIMIT)) begin
                            entry_hi_ack[idx] = p.ack_number;
                            r.ack_advanced = 1'b1;
                        end
                        // expected ack latches once, on activation
                        if (!entry_active[idx]) begin
                            entry_active[idx] = 1'b1;
                            entry_exp_ack[idx] = exp_ack;
                        end
                        r.highest_ack_out = entry_hi_ack[idx];
                        r.expected_ack_out = entry_exp_ack[idx];
                        r.flow_active = 1'b1;
                        return r;
                    end
                end else if (!have_free) begin
                    have_free = 1'b1;
                    free_idx = idx;
                end
            end
            if (!have_free) begin
                r.status = STATUS_FULL;
                return r;
            end
            // new flow takes the lowest free way
            entry_valid[free_idx] = 1'b1;
            entry_addrs[free_idx] = addrs;
            entry_ports[free_idx] = ports;
            entry_hi_ack[free_idx] = p.ack_number;
            entry_exp_ack[free_idx] = exp_ack;
            entry_active[free_idx] = 1'b0;
            r.status = STATUS_INSERTED;
            r.highest_ack_out = p.ack_number;
            r.expected_ack_out = exp_ack;
            r.ack_advanced = 1'b1;
            return r;
        endfunction

        function void note_packet(packet_t p);
            expected_flow_results.push_back(predict_flow_result(p));
        endfunction

        task report_mismatch(string msg);
            if (mismatches < REPORT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_result_word(flow_result_t got);
            flow_result_t want;
            if (expected_flow_results.size() == 0) begin
                report_mismatch($sformatf("result word %h with no packet outstanding", got));
                return;
            end
            want = expected_flow_results.pop_front();
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("highest_ack_out", got.highest_ack_out, want.highest_ack_out);
            compare_field("expected_ack_out", got.expected_ack_out, want.expected_ack_out);
            compare_field("ack_advanced", 32'(got.ack_advanced), 32'(want.ack_advanced));
            compare_field("flow_active", 32'(got.flow_active), 32'(want.flow_active));
        endtask
    endclass

    ack_table_board board;

    tcp_flow_highest_ack_table_unit #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .BUCKET_WAYS   (BUCKET_WAYS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // plain TCP header with standard 20-byte headers and no payload
    function automatic packet_t tcp_packet(logic [31:0] sip, logic [31:0] dip,
                                           logic [15:0] sport, logic [15:0] dport,
                                           logic [31:0] seq, logic [31:0] ack);
        packet_t p;
        p = '0;
        p.protocol = TFHAT_PROTO_TCP;
        p.source_ip = sip;
        p.dest_ip = dip;
        p.source_port = sport;
        p.dest_port = dport;
        p.seq_number = seq;
        p.ack_number = ack;
        p.ip_total_len = 16'd40;
        p.ip_header_words = 4'd5;
        p.tcp_header_words = 4'd5;
        return p;
    endfunction

    // random TCP header, lengths mostly plausible, acks often near the top
    function automatic packet_t random_tcp_packet();
        packet_t p;
        p.protocol = TFHAT_PROTO_TCP;
        p.source_ip = $urandom;
        p.dest_ip = $urandom;
        p.source_port = 16'($urandom);
        p.dest_port = 16'($urandom);
        p.seq_number = $urandom;
        p.ack_number = ($urandom_range(0, 3) == 0) ? ($urandom | 32'hFFF0_0000) : $urandom;
        p.ip_total_len = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(40, 1500))
                                                     : 16'($urandom);
        p.ip_header_words = ($urandom_range(0, 9) < 7) ? 4'd5 : 4'($urandom);
        p.tcp_header_words = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(5, 8))
                                                        : 4'($urandom);
        return p;
    endfunction

    // next packet of a known flow: same key, ack moves in various ways
    function automatic packet_t next_packet_of_flow(packet_t f);
        packet_t p;
        p = random_tcp_packet();
        p.source_ip = f.source_ip;
        p.dest_ip = f.dest_ip;
        p.source_port = f.source_port;
        p.dest_port = f.dest_port;
        p.seq_number = f.seq_number + $urandom_range(0, 1500);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: p.ack_number = f.ack_number + $urandom_range(0, 4000);
            5, 6:          p.ack_number = f.ack_number - $urandom_range(1, 4000);
            7:             p.ack_number = f.ack_number;
            8:             p.ack_number = (f.ack_number > TFHAT_TOP_QUARTER_FLOOR) ?
                                          $urandom_range(0, 32'h3FFF_FFFF) : $urandom;
            default:       p.ack_number = $urandom;
        endcase
        return p;
    endfunction

    // flows whose keys all hash to one bucket
    function automatic void build_crowded_group(int unsigned mates);
        packet_t     p;
        int unsigned target;
        p = random_tcp_packet();
        target = bucket_index({p.dest_ip, p.source_ip}, {p.dest_port, p.source_port});
        crowd_group.delete();
        crowd_group.push_back(p);
        while (crowd_group.size() < mates) begin
            p.source_port++;
            if (p.source_port == 16'd0)
                p.source_ip = $urandom;
            if (bucket_index({p.dest_ip, p.source_ip}, {p.dest_port, p.source_port}) == target) begin
                p.ack_number = $urandom;
                crowd_group.push_back(p);
            end
        end
    endfunction

    function automatic void remember_flow(packet_t p);
        if (flow_pool.size() < POOL_LIMIT)
            flow_pool.push_back(p);
        else
            flow_pool[$urandom_range(0, POOL_LIMIT - 1)] = p;
    endfunction

    // one word onto s_axis; bursts of back-to-back words, random gaps between
    task automatic send_packet(packet_t p);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= p;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_packet(p);
        words_sent++;
    endtask

    // receiver: open, random or patterned stalls, one long hold-off
    initial begin
        rx_mode_t    mode;
        int unsigned mode_left;
        int unsigned hold_left;
        bit          long_hold_done;
        logic [7:0]  stall_pattern;
        logic        rdy;
        m_axis_tready <= 1'b0;
        mode = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        long_hold_done = 1'b0;
        stall_pattern = 8'b1101_0110;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!long_hold_done && words_sent >= HOLD_TRIGGER) begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES - 1;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 200);
                    stall_pattern = 8'($urandom) | 8'h01;
                end
                mode_left--;
                case (mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_RANDOM: rdy = ($urandom_range(0, 99) < 60);
                    default: begin
                        stall_pattern = {stall_pattern[6:0], stall_pattern[7]};
                        rdy = stall_pattern[0];
                    end
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_result_word(flow_result_t'(m_axis_tdata));
    end

    // stimulus and end of run
    initial begin
        packet_t     p;
        int unsigned tcp_sent;
        int unsigned pick;
        int unsigned k;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        aresetn <= 1'b0;
        words_sent = 0;
        burst_left = 0;
        tcp_sent = 0;
        board = new;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // non-TCP: all ones, all zeros, protocol next to TCP
        p = '1;
        p.protocol = 8'd0;
        send_packet(p);
        p = '0;
        p.protocol = 8'hFF;
        send_packet(p);
        p = tcp_packet(32'h0A00_0001, 32'h0A00_0002, 16'd1234, 16'd80, 32'd0, 32'd0);
        p.protocol = 8'd7;
        send_packet(p);

        // all-zero TCP header, zero lengths
        p = '0;
        p.protocol = TFHAT_PROTO_TCP;
        send_packet(p);

        // all-ones flow: insert, equal ack, wrap to bottom quarter, stale ack
        p = '1;
        p.protocol = TFHAT_PROTO_TCP;
        send_packet(p);
        send_packet(p);
        p.ack_number = 32'd5;
        send_packet(p);
        p.ack_number = 32'd3;
        p.seq_number = 32'd100;
        send_packet(p);

        // headers longer than the packet; the top-quarter floor itself does not wrap
        p = tcp_packet(32'hC0A8_0001, 32'hC0A8_0002, 16'd40000, 16'd443,
                       32'h0000_1000, TFHAT_TOP_QUARTER_FLOOR);
        p.ip_total_len = 16'd20;
        p.ip_header_words = 4'hF;
        p.tcp_header_words = 4'hF;
        send_packet(p);
        p.ack_number = 32'd1;
        send_packet(p);
        p.ack_number = TFHAT_TOP_QUARTER_FLOOR + 32'd1;
        send_packet(p);
        p.ack_number = TFHAT_LOW_QUARTER_LIMIT - 32'd1;
        send_packet(p);

        // ack at the low-quarter limit does not wrap; equal ack advances
        p = tcp_packet(32'h1111_2222, 32'h3333_4444, 16'd555, 16'd666,
                       32'h8000_0000, 32'hFFFF_FFF0);
        send_packet(p);
        p.ack_number = TFHAT_LOW_QUARTER_LIMIT;
        send_packet(p);
        p.ack_number = 32'hFFFF_FFF0;
        send_packet(p);

        // same hosts in the other direction are a separate flow
        p = tcp_packet(32'h0A00_0001, 32'h0A00_0002, 16'd5000, 16'd22, 32'd10, 32'd20);
        send_packet(p);
        p = tcp_packet(32'h0A00_0002, 32'h0A00_0001, 16'd22, 16'd5000, 32'd20, 32'd10);
        send_packet(p);

        // five flows in one bucket: the fifth finds it full, the first still hits
        build_crowded_group(5);
        foreach (crowd_group[i])
            send_packet(crowd_group[i]);
        send_packet(crowd_group[4]);
        send_packet(crowd_group[0]);

        // random traffic
        while (tcp_sent < RANDOM_TCP_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                p = random_tcp_packet();
                p.seq_number = $urandom;
                p.ip_total_len = 16'($urandom);
                do p.protocol = 8'($urandom); while (p.protocol == TFHAT_PROTO_TCP);
                send_packet(p);
            end else if (pick < 10) begin
                build_crowded_group($urandom_range(5, 6));
                foreach (crowd_group[i]) begin
                    send_packet(crowd_group[i]);
                    remember_flow(crowd_group[i]);
                end
                tcp_sent += crowd_group.size();
            end else if (pick < 22 || flow_pool.size() == 0) begin
                p = random_tcp_packet();
                send_packet(p);
                remember_flow(p);
                tcp_sent++;
            end else begin
                k = $urandom_range(0, flow_pool.size() - 1);
                p = next_packet_of_flow(flow_pool[k]);
                flow_pool[k] = p;
                send_packet(p);
                tcp_sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain
        while (board.expected_flow_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.expected_flow_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/tfhat_pkg.sv
sv/tfhat_hash.sv
sv/tfhat_bucket_ram.sv
sv/tcp_flow_highest_ack_table_unit.sv
verif/testbench.sv
